/* rtl/core/svtd_pkg.sv */
package svtd_pkg;

    // request kinds
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_CLOSE = 3'd1;
    localparam logic [2:0] CMD_OPEN  = 3'd2;
    localparam logic [2:0] CMD_PULSE = 3'd3;

    // mode codes as held in the mode register
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_NORMALLY_OPEN  = 3'd0;
    localparam logic [2:0] CFG_SPECIAL_VALVE  = 3'd1;
    localparam logic [2:0] CFG_PULSE_WAIT_MS  = 3'd2;
    localparam logic [2:0] CFG_MAX_POWER_MS   = 3'd3;
    localparam logic [2:0] CFG_RELIEF_WAIT_MS = 3'd4;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // register reset values
    localparam logic [15:0] PULSE_WAIT_RST  = 16'd500;
    localparam logic [15:0] MAX_POWER_RST   = 16'd1000;
    localparam logic [15:0] RELIEF_WAIT_RST = 16'd100;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic       req_type;
        logic [2:0] command;
    } svtd_in_t;

    typedef struct packed {
        logic       drive_level;
        logic       valve_open;
        logic [1:0] active_mode;
        logic       relieving;
        logic       error_flag;
    } svtd_out_t;

endpackage

/* rtl/core/solenoid_valve_timed_driver_top.sv */
// path: a word accepted into the input register has its result registered in the result register
// (input register, then result register)
// throughput: one word per cycle while the result side does not stall; the state update is a single
// pass of compares between the input register and the result register
// reset: rst_n asynchronous, active low; clears pipeline valids, valve state, error flag
// and loads the configuration registers with their default values
module solenoid_valve_timed_driver_top
    import svtd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  svtd_in_t               in_data,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output svtd_out_t              out_data,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic        normally_open_reg;
    logic        special_valve_reg;
    logic [15:0] pulse_wait_reg;
    logic [15:0] max_power_reg;
    logic [15:0] relief_wait_reg;

    // valve state
    logic        drive_reg,   drive_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [1:0]  mode_reg,    mode_next;
    logic        relief_reg,  relief_next;
    logic        error_reg,   error_next;

    // pipeline
    logic        s1_valid_reg;
    svtd_in_t    s1_data_reg;
    logic        out_valid_reg;
    svtd_out_t   out_data_reg;
    svtd_out_t   out_data_next;

    logic        out_ready;
    logic        s1_advance;
    logic        in_accept;
    logic        open_level;
    logic        close_level;

    // result register frees up when empty or when its word is taken this cycle
    assign out_ready  = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_ready;
    // input register refills when empty or when it moves on this cycle
    assign in_stall   = s1_valid_reg && !out_ready;
    assign in_accept  = in_valid && !in_stall;

    assign open_level  = !normally_open_reg;
    assign close_level = normally_open_reg;

    // configuration writes; indexes beyond the list fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normally_open_reg <= 1'b0;
            special_valve_reg <= 1'b0;
            pulse_wait_reg    <= PULSE_WAIT_RST;
            max_power_reg     <= MAX_POWER_RST;
            relief_wait_reg   <= RELIEF_WAIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NORMALLY_OPEN:  normally_open_reg <= cfg_data[0];
                CFG_SPECIAL_VALVE:  special_valve_reg <= cfg_data[0];
                CFG_PULSE_WAIT_MS:  pulse_wait_reg    <= cfg_data;
                CFG_MAX_POWER_MS:   max_power_reg     <= cfg_data;
                CFG_RELIEF_WAIT_MS: relief_wait_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // one pass of the valve update for the word in the input register
    always_comb
    begin
        drive_next   = drive_reg;
        elapsed_next = elapsed_reg;
        mode_next    = mode_reg;
        relief_next  = relief_reg;
        error_next   = error_reg;

        if (s1_data_reg.req_type == REQ_TICK)
        begin
            // saturating millisecond count
            if (elapsed_reg != ELAPSED_MAX)
            begin
                elapsed_next = elapsed_reg + 16'd1;
            end

            // pulse expiry closes the valve and drops back to no mode
            if (mode_next == MODE_PULSE && elapsed_next >= pulse_wait_reg)
            begin
                drive_next   = close_level;
                elapsed_next = '0;
                mode_next    = MODE_NONE;
            end

            if (special_valve_reg)
            begin
                if (drive_next)
                begin
                    // held high too long: drop the pin and mark relief
                    if (elapsed_next >= max_power_reg)
                    begin
                        drive_next   = 1'b0;
                        elapsed_next = '0;
                        relief_next  = 1'b1;
                    end
                    // re-energise once the relief wait has run with the mark still set
                    if (relief_next && elapsed_next >= relief_wait_reg)
                    begin
                        drive_next   = 1'b1;
                        elapsed_next = '0;
                        relief_next  = 1'b0;
                    end
                end
                else if (relief_next && elapsed_next >= relief_wait_reg)
                begin
                    relief_next = 1'b0;
                end
            end
        end
        else if (s1_data_reg.command != {1'b0, mode_reg})
        begin
            // a repeat of the current mode is ignored
            case (s1_data_reg.command) inside
                CMD_NONE:
                begin
                    mode_next = MODE_NONE;
                end
                CMD_CLOSE:
                begin
                    drive_next   = close_level;
                    elapsed_next = '0;
                    mode_next    = s1_data_reg.command[1:0];
                end
                CMD_OPEN, CMD_PULSE:
                begin
                    drive_next   = open_level;
                    elapsed_next = '0;
                    mode_next    = s1_data_reg.command[1:0];
                end
                default:
                begin
                    // unknown code: sticky error, nothing else moves
                    error_next = 1'b1;
                end
            endcase
        end

        out_data_next.drive_level = drive_next;
        out_data_next.valve_open  = (drive_next == open_level);
        out_data_next.active_mode = mode_next;
        out_data_next.relieving   = relief_next;
        out_data_next.error_flag  = error_next;
    end

    // valve state commits when a word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg   <= 1'b0;
            elapsed_reg <= '0;
            mode_reg    <= MODE_NONE;
            relief_reg  <= 1'b0;
            error_reg   <= 1'b0;
        end
        else if (s1_advance)
        begin
            drive_reg   <= drive_next;
            elapsed_reg <= elapsed_next;
            mode_reg    <= mode_next;
            relief_reg  <= relief_next;
            error_reg   <= error_next;
        end
    end

    // input register valid and result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sim/tb_solenoid_valve_timed_driver_top.sv */
`timescale 1ns / 100ps

module tb_solenoid_valve_timed_driver_top;
    import svtd_pkg::*;

    // run limits
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned RANDOM_PHASES = 16;
    localparam int unsigned PHASE_WORDS   = 100;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned REPORT_LIMIT  = 10;

    // codes not named in the package
    localparam logic [1:0] MODE_CLOSE         = 2'd1;
    localparam logic [1:0] MODE_OPEN          = 2'd2;
    localparam logic [2:0] CMD_UNKNOWN_FIRST  = 3'd4;
    localparam logic [2:0] CMD_UNKNOWN_LAST   = 3'd7;
    localparam logic [2:0] CFG_SPARE_FIRST    = 3'd5;
    localparam logic [2:0] CFG_SPARE_LAST     = 3'd7;

    // valve state mirror: own copy of the registers and the pin state,
    // advanced once per accepted word, results queued in order
    class valve_scoreboard;
        logic        norm_open;
        logic        special;
        logic [15:0] pulse_wait;
        logic [15:0] max_power;
        logic [15:0] relief_wait;
        logic        drive;
        logic [15:0] elapsed;
        logic [1:0]  mode;
        logic        relief;
        logic        sticky_err;
        svtd_out_t   predicted_outputs[$];
        int          mismatches;

        function new();
            norm_open   = 1'b0;
            special     = 1'b0;
            pulse_wait  = PULSE_WAIT_RST;
            max_power   = MAX_POWER_RST;
            relief_wait = RELIEF_WAIT_RST;
            drive       = 1'b0;
            elapsed     = '0;
            mode        = MODE_NONE;
            relief      = 1'b0;
            sticky_err  = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_NORMALLY_OPEN:  norm_open   = val[0];
                CFG_SPECIAL_VALVE:  special     = val[0];
                CFG_PULSE_WAIT_MS:  pulse_wait  = val;
                CFG_MAX_POWER_MS:   max_power   = val;
                CFG_RELIEF_WAIT_MS: relief_wait = val;
                default: ;
            endcase
        endfunction

        function logic open_level();
            return ~norm_open;
        endfunction

        function void set_drive(logic lvl);
            drive   = lvl;
            elapsed = '0;
        endfunction

        function void tick_valve();
            if (elapsed != ELAPSED_MAX)
                elapsed++;
            if (mode == MODE_PULSE && elapsed >= pulse_wait)
            begin
                set_drive(norm_open);
                mode = MODE_NONE;
            end
            if (special)
            begin
                if (drive)
                begin
                    if (elapsed >= max_power)
                    begin
                        set_drive(1'b0);
                        relief = 1'b1;
                    end
                    // re-energise once the relief wait has run with the mark still set
                    if (relief && elapsed >= relief_wait)
                    begin
                        set_drive(1'b1);
                        relief = 1'b0;
                    end
                end
                else if (relief && elapsed >= relief_wait)
                begin
                    relief = 1'b0;
                end
            end
        endfunction

        function void command_valve(logic [2:0] cmd);
            if (cmd == {1'b0, mode})
                return;
            case (cmd)
                CMD_NONE:  mode = MODE_NONE;
                CMD_CLOSE:
                begin
                    set_drive(norm_open);
                    mode = MODE_CLOSE;
                end
                CMD_OPEN:
                begin
                    set_drive(open_level());
                    mode = MODE_OPEN;
                end
                CMD_PULSE:
                begin
                    set_drive(open_level());
                    mode = MODE_PULSE;
                end
                default: sticky_err = 1'b1;
            endcase
        endfunction

        function void note_word(svtd_in_t w);
            svtd_out_t r;
            if (w.req_type == REQ_TICK)
                tick_valve();
            else
                command_valve(w.command);
            r.drive_level = drive;
            r.valve_open  = (drive == open_level());
            r.active_mode = mode;
            r.relieving   = relief;
            r.error_flag  = sticky_err;
            predicted_outputs.push_back(r);
        endfunction

        function void report(string what, int want, int got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch %s: expected %0d actual %0d", what, want, got);
        endfunction

        function void compare_field(string what, logic [1:0] want, logic [1:0] got);
            if (want !== got)
                report(what, int'(want), int'(got));
        endfunction

        function void check_result(svtd_out_t got);
            svtd_out_t want;
            if (predicted_outputs.size() == 0)
            begin
                report("unexpected word", 0, int'(got));
                return;
            end
            want = predicted_outputs.pop_front();
            compare_field("drive_level", want.drive_level, got.drive_level);
            compare_field("valve_open", want.valve_open, got.valve_open);
            compare_field("active_mode", want.active_mode, got.active_mode);
            compare_field("relieving", want.relieving, got.relieving);
            compare_field("error_flag", want.error_flag, got.error_flag);
        endfunction

        function int closing_count();
            if (predicted_outputs.size() != 0)
                report("words still owed", 0, predicted_outputs.size());
            return mismatches;
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    svtd_in_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    svtd_out_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    valve_scoreboard sb;
    int unsigned     cycle_count;
    int              stall_left;
    // per-phase switches for random idling on each side
    bit              send_idle;
    bit              recv_idle;

    solenoid_valve_timed_driver_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check each word taken, then hold stall for a drawn number of cycles;
    // values read here are those from before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_data);
                stall_left = recv_idle ? $urandom_range(0, 7) : 0;
                out_stall <= (stall_left > 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= (stall_left > 0);
            end
        end
    end

    // offer one word after a drawn gap, return once it is taken
    task automatic send_word(input svtd_in_t w);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(w);
    endtask

    // tick with random don't-care command bits
    task automatic send_tick();
        svtd_in_t w;
        w.req_type = REQ_TICK;
        w.command  = 3'($urandom);
        send_word(w);
    endtask

    task automatic send_command(input logic [2:0] cmd);
        svtd_in_t w;
        w.req_type = REQ_COMMAND;
        w.command  = cmd;
        send_word(w);
    endtask

    // mostly ticks, some valid commands, a little unknown-code noise
    task automatic send_random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 72)
            send_tick();
        else if (roll < 97)
            send_command({1'b0, 2'($urandom)});
        else
            send_command(3'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST)));
    endtask

    // hold the sender off until every owed word is back and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, val);
    endtask

    // millisecond setting: mostly short so timers expire often, sometimes an extreme
    function automatic logic [15:0] pick_ms();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    initial
    begin
        sb          = new();
        cycle_count = 0;
        stall_left  = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, default registers: repeats ignored, unknown codes latch the error
        send_tick();
        send_command(CMD_NONE);
        send_command(CMD_CLOSE);
        send_command(CMD_CLOSE);
        send_command(CMD_OPEN);
        send_command(CMD_PULSE);
        send_command(CMD_UNKNOWN_FIRST);
        send_command(CMD_UNKNOWN_LAST);
        send_tick();
        send_command(CMD_NONE);
        drain();

        // normally open special valve with short timers
        write_register(CFG_NORMALLY_OPEN, 16'd1);
        write_register(CFG_SPECIAL_VALVE, 16'd1);
        write_register(CFG_PULSE_WAIT_MS, 16'd2);
        write_register(CFG_MAX_POWER_MS, 16'd3);
        write_register(CFG_RELIEF_WAIT_MS, 16'd1);
        // spare indexes must leave the registers alone
        for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
            write_register(3'(i), 16'hFFFF);
        // pulse runs out and closes high, then power relief and mark clearing
        send_command(CMD_PULSE);
        send_tick();
        send_tick();
        repeat (5) send_tick();
        send_command(CMD_OPEN);
        send_command(CMD_NONE);
        send_tick();
        drain();

        // zero timers: relief fires and re-energises in the same tick
        write_register(CFG_NORMALLY_OPEN, 16'd0);
        write_register(CFG_MAX_POWER_MS, 16'd0);
        write_register(CFG_RELIEF_WAIT_MS, 16'd0);
        write_register(CFG_PULSE_WAIT_MS, 16'd0);
        send_command(CMD_PULSE);
        send_tick();
        send_command(CMD_OPEN);
        send_tick();
        send_tick();

        // random phases, each with fresh registers and its own idling mix
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            write_register(CFG_NORMALLY_OPEN, 16'($urandom_range(0, 1)));
            write_register(CFG_SPECIAL_VALVE, 16'($urandom_range(0, 4) != 0));
            write_register(CFG_PULSE_WAIT_MS, pick_ms());
            write_register(CFG_MAX_POWER_MS, pick_ms());
            write_register(CFG_RELIEF_WAIT_MS, pick_ms());
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_word();
        end

        drain();
        if (sb.closing_count() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* solenoid_valve_timed_driver_top.f */
rtl/core/svtd_pkg.sv
rtl/core/solenoid_valve_timed_driver_top.sv
sim/tb_solenoid_valve_timed_driver_top.sv
